@@ rtl/core/lavm_pkg.sv @@
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared widths, word types and side-band types for the view matrix pipeline.
// ----------------------------------------------------------------------------
package lavm_pkg;

   localparam int COORD_W     = 32;  // input coordinates
   localparam int DIFF_W      = 33;  // difference of two coordinates
   localparam int VEC_W       = 65;  // signed vector component fed to normalize
   localparam int MAG_W       = 64;  // magnitude of such a component
   localparam int MANT_W      = 31;  // aligned magnitude, top bit at 30
   localparam int SUMSQ_W     = 64;  // sum of three squared mantissas
   localparam int ROOT_W      = 32;  // integer square root of the sum
   localparam int NUM_W       = 62;  // dividend of the scaling divide
   localparam int QUO_W       = 31;  // scaled magnitude, at most 2^30
   localparam int BASIS_W     = 32;  // Q2.30 basis terms
   localparam int BASIS_FRAC  = 30;
   localparam int SHIFT_W     = 48;  // translation terms
   localparam int PROD_W      = 64;  // 32 x 32 products
   localparam int NORM_SHIFTS = 6;   // alignment steps of 32, 16, 8, 4, 2, 1

   typedef struct packed {
      logic signed [COORD_W-1:0] eye_x;
      logic signed [COORD_W-1:0] eye_y;
      logic signed [COORD_W-1:0] eye_z;
      logic signed [COORD_W-1:0] focus_x;
      logic signed [COORD_W-1:0] focus_y;
      logic signed [COORD_W-1:0] focus_z;
      logic signed [COORD_W-1:0] up_x;
      logic signed [COORD_W-1:0] up_y;
      logic signed [COORD_W-1:0] up_z;
   } req_word_type;

   typedef struct packed {
      logic signed [BASIS_W-1:0] row0_u;
      logic signed [BASIS_W-1:0] row0_v;
      logic signed [BASIS_W-1:0] row0_n;
      logic signed [SHIFT_W-1:0] row0_shift;
      logic signed [BASIS_W-1:0] row1_u;
      logic signed [BASIS_W-1:0] row1_v;
      logic signed [BASIS_W-1:0] row1_n;
      logic signed [SHIFT_W-1:0] row1_shift;
      logic signed [BASIS_W-1:0] row2_u;
      logic signed [BASIS_W-1:0] row2_v;
      logic signed [BASIS_W-1:0] row2_n;
      logic signed [SHIFT_W-1:0] row2_shift;
   } rsp_word_type;

   // Carried alongside the first normalization: eye point and up minus eye.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][DIFF_W-1:0]  w;
   } fwd_side_type;

   // Carried alongside the second normalization: eye point and N.
   typedef struct packed {
      logic [2:0][COORD_W-1:0] eye;
      logic [2:0][BASIS_W-1:0] n;
   } cross_side_type;

endpackage

@@ rtl/core/lavm_norm3.sv @@
// ----------------------------------------------------------------------------
// Three-component vector normalizer
// Aligns the largest magnitude to [2^30, 2^31), takes the integer square root
// of the sum of squares one bit per stage, and scales each component to Q2.30
// with a restoring divide, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lavm_norm3 import lavm_pkg::*; #(
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic signed [VEC_W-1:0]   in_vec [3],
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic signed [BASIS_W-1:0] out_vec [3],
   output logic [SIDE_W-1:0]         out_side
);

   localparam int ROOT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;

   typedef struct packed {
      logic [2:0]        neg;
      logic [SIDE_W-1:0] side;
   } tag_type;

   typedef struct packed {
      logic [2:0][MANT_W-1:0] mn;
      logic [2:0]             neg;
      logic                   zero;
      logic [SIDE_W-1:0]      side;
   } car_type;

   // Alignment phase.
   logic [NORM_SHIFTS:0] sh_vld_ff;
   logic [MAG_W-1:0]     sh_mag_ff [NORM_SHIFTS+1][3];
   logic [MAG_W-1:0]     sh_mag_in [NORM_SHIFTS+1][3];
   logic [MAG_W-1:0]     sh_or_ff  [NORM_SHIFTS+1];
   logic [MAG_W-1:0]     sh_or_in  [NORM_SHIFTS+1];
   tag_type              sh_tag_ff [NORM_SHIFTS+1];

   // Squares and their sum.
   logic                 sq_vld_ff;
   logic [2*MANT_W-1:0]  sq_prod_ff [3];
   car_type              sq_car_ff;
   car_type              sq_car_in;

   // Square root phase.
   logic [ROOT_STEPS:0]  rt_vld_ff;
   logic [ROOT_W+1:0]    rt_rem_ff  [ROOT_STEPS+1];
   logic [ROOT_W+1:0]    rt_rem_in  [ROOT_STEPS+1];
   logic [ROOT_W-1:0]    rt_root_ff [ROOT_STEPS+1];
   logic [ROOT_W-1:0]    rt_root_in [ROOT_STEPS+1];
   logic [SUMSQ_W-1:0]   rt_s_ff    [ROOT_STEPS+1];
   car_type              rt_car_ff  [ROOT_STEPS+1];

   // Divide phase.
   logic [DIV_STEPS:0]   dv_vld_ff;
   logic [NUM_W-1:0]     dv_num_ff [DIV_STEPS+1][3];
   logic [NUM_W-1:0]     dv_num_in [3];
   logic [ROOT_W-1:0]    dv_rem_ff [DIV_STEPS+1][3];
   logic [ROOT_W-1:0]    dv_rem_in [DIV_STEPS+1][3];
   logic [QUO_W-1:0]     dv_q_ff   [DIV_STEPS+1][3];
   logic [QUO_W-1:0]     dv_q_in   [DIV_STEPS+1][3];
   logic [ROOT_W-1:0]    dv_len_ff [DIV_STEPS+1];
   car_type              dv_car_ff [DIV_STEPS+1];

   logic                      out_valid_ff;
   logic signed [BASIS_W-1:0] out_vec_ff [3];
   logic signed [BASIS_W-1:0] out_vec_in [3];
   logic [SIDE_W-1:0]         out_side_ff;

   // Magnitudes, and the alignment shifts driven by the OR of all three:
   // its leading one sits where the largest magnitude has its leading one.
   always_comb begin
      int amt;
      logic hit;
      for (int i = 0; i < 3; i++) begin
         sh_mag_in[0][i] = in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
      end
      sh_or_in[0] = sh_mag_in[0][0] | sh_mag_in[0][1] | sh_mag_in[0][2];
      for (int k = 0; k < NORM_SHIFTS; k++) begin
         amt = 32 >> k;
         hit = (sh_or_ff[k] >> (MAG_W - amt)) == '0;
         sh_or_in[k+1] = hit ? sh_or_ff[k] << amt : sh_or_ff[k];
         for (int i = 0; i < 3; i++) begin
            sh_mag_in[k+1][i] = hit ? sh_mag_ff[k][i] << amt : sh_mag_ff[k][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NORM_SHIFTS; k++) begin
         sh_or_ff[k] <= sh_or_in[k];
         for (int i = 0; i < 3; i++) begin
            sh_mag_ff[k][i] <= sh_mag_in[k][i];
         end
      end
      sh_tag_ff[0].neg  <= {in_vec[2][VEC_W-1], in_vec[1][VEC_W-1], in_vec[0][VEC_W-1]};
      sh_tag_ff[0].side <= in_side;
      for (int k = 0; k < NORM_SHIFTS; k++) begin
         sh_tag_ff[k+1] <= sh_tag_ff[k];
      end
   end

   // Leading one now at bit 63; the top 31 bits are the magnitude truncated
   // so that the largest one lands in [2^30, 2^31).
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_car_in.mn[i] = sh_mag_ff[NORM_SHIFTS][i][MAG_W-1 -: MANT_W];
      end
      sq_car_in.neg  = sh_tag_ff[NORM_SHIFTS].neg;
      sq_car_in.zero = sh_or_ff[NORM_SHIFTS] == '0;
      sq_car_in.side = sh_tag_ff[NORM_SHIFTS].side;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_prod_ff[i] <= sq_car_in.mn[i] * sq_car_in.mn[i];
      end
      sq_car_ff <= sq_car_in;
      rt_s_ff[0] <= SUMSQ_W'(sq_prod_ff[0]) + SUMSQ_W'(sq_prod_ff[1])
                    + SUMSQ_W'(sq_prod_ff[2]);
      rt_car_ff[0] <= sq_car_ff;
   end

   // Digit-by-digit square root, one root bit per stage.
   always_comb begin
      int b;
      logic [ROOT_W+3:0] rem_sh;
      logic [ROOT_W+3:0] trial;
      logic ge;
      rt_rem_in[0]  = '0;
      rt_root_in[0] = '0;
      for (int j = 0; j < ROOT_STEPS; j++) begin
         b      = ROOT_STEPS - 1 - j;
         rem_sh = {rt_rem_ff[j], rt_s_ff[j][2*b +: 2]};
         trial  = {2'b00, rt_root_ff[j], 2'b01};
         ge     = rem_sh >= trial;
         rt_rem_in[j+1]  = ge ? (ROOT_W+2)'(rem_sh - trial) : (ROOT_W+2)'(rem_sh);
         rt_root_in[j+1] = {rt_root_ff[j][ROOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= ROOT_STEPS; j++) begin
         rt_rem_ff[j]  <= rt_rem_in[j];
         rt_root_ff[j] <= rt_root_in[j];
      end
      for (int j = 0; j < ROOT_STEPS; j++) begin
         rt_s_ff[j+1]   <= rt_s_ff[j];
         rt_car_ff[j+1] <= rt_car_ff[j];
      end
   end

   // Dividend is the mantissa at 30 fraction bits plus half the length, which
   // rounds the quotient half up. The quotient never exceeds 2^30, so the top
   // 31 dividend bits are already below the length.
   always_comb begin
      int b;
      logic [ROOT_W:0] t;
      logic ge;
      for (int i = 0; i < 3; i++) begin
         dv_num_in[i]    = {1'b0, rt_car_ff[ROOT_STEPS].mn[i], BASIS_FRAC'(0)}
                           + NUM_W'(rt_root_ff[ROOT_STEPS][ROOT_W-1:1]);
         dv_rem_in[0][i] = {1'b0, dv_num_in[i][NUM_W-1 -: QUO_W]};
         dv_q_in[0][i]   = '0;
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         b = DIV_STEPS - 1 - j;
         for (int i = 0; i < 3; i++) begin
            t  = {dv_rem_ff[j][i], dv_num_ff[j][i][b]};
            ge = t >= {1'b0, dv_len_ff[j]};
            dv_rem_in[j+1][i]  = ge ? ROOT_W'(t - {1'b0, dv_len_ff[j]}) : t[ROOT_W-1:0];
            dv_q_in[j+1][i]    = dv_q_ff[j][i];
            dv_q_in[j+1][i][b] = ge;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= DIV_STEPS; j++) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[j][i] <= dv_rem_in[j][i];
            dv_q_ff[j][i]   <= dv_q_in[j][i];
         end
      end
      for (int i = 0; i < 3; i++) begin
         dv_num_ff[0][i] <= dv_num_in[i];
      end
      dv_len_ff[0] <= rt_root_ff[ROOT_STEPS];
      dv_car_ff[0] <= rt_car_ff[ROOT_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) begin
         for (int i = 0; i < 3; i++) begin
            dv_num_ff[j+1][i] <= dv_num_ff[j][i];
         end
         dv_len_ff[j+1] <= dv_len_ff[j];
         dv_car_ff[j+1] <= dv_car_ff[j];
      end
   end

   // A zero-length vector normalizes to zero.
   always_comb begin
      logic signed [BASIS_W-1:0] q;
      for (int i = 0; i < 3; i++) begin
         q = {1'b0, dv_q_ff[DIV_STEPS][i]};
         if (dv_car_ff[DIV_STEPS].zero) begin
            out_vec_in[i] = '0;
         end else if (dv_car_ff[DIV_STEPS].neg[i]) begin
            out_vec_in[i] = -q;
         end else begin
            out_vec_in[i] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         out_vec_ff[i] <= out_vec_in[i];
      end
      out_side_ff <= dv_car_ff[DIV_STEPS].side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_vld_ff    <= '0;
         sq_vld_ff    <= 1'b0;
         rt_vld_ff    <= '0;
         dv_vld_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         sh_vld_ff    <= {sh_vld_ff[NORM_SHIFTS-1:0], in_valid};
         sq_vld_ff    <= sh_vld_ff[NORM_SHIFTS];
         rt_vld_ff    <= {rt_vld_ff[ROOT_STEPS-1:0], sq_vld_ff};
         dv_vld_ff    <= {dv_vld_ff[DIV_STEPS-1:0], rt_vld_ff[ROOT_STEPS]};
         out_valid_ff <= dv_vld_ff[DIV_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

@@ rtl/core/look_at_view_matrix_unit.sv @@
// ----------------------------------------------------------------------------
// Look-at view matrix unit
// Builds the 3x4 camera view matrix from eye, focus and up points.
// ----------------------------------------------------------------------------
// The result word is strobed after start is taken and passes stage A, the two
// normalizers (74 stages each, root and divide a bit a stage) and stages B to F.
// Throughput: one word per cycle; busy stays low and no stage ever stalls.
// Reset clears all valid bits, so no stale word is strobed after reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit import lavm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);

   localparam int FWD_W   = $bits(fwd_side_type);
   localparam int CROSS_W = $bits(cross_side_type);

   // Round a Q4.60 value to Q2.30 half away from zero, then saturate.
   function automatic logic signed [BASIS_W-1:0] round_basis(logic signed [VEC_W-1:0] x);
      logic [MAG_W-1:0] a;
      logic [MAG_W-1:0] q;
      logic signed [BASIS_W-1:0] r;
      a = x[VEC_W-1] ? MAG_W'(-x) : MAG_W'(x);
      q = (a + (MAG_W'(1) << (BASIS_FRAC - 1))) >> BASIS_FRAC;
      if (!x[VEC_W-1]) begin
         r = (q > MAG_W'(32'h7fff_ffff)) ? 32'sh7fff_ffff : BASIS_W'(q);
      end else begin
         r = (q > MAG_W'(32'h8000_0000)) ? 32'sh8000_0000 : BASIS_W'(-q);
      end
      return r;
   endfunction

   // Exact sum of three products rounded half up to the coordinate scale.
   // The sum stays below 2^64, so the result always fits in 48 bits.
   function automatic logic signed [SHIFT_W-1:0] dot_round(
      logic signed [PROD_W-1:0] p0,
      logic signed [PROD_W-1:0] p1,
      logic signed [PROD_W-1:0] p2
   );
      logic signed [PROD_W+1:0] s;
      s = (PROD_W+2)'(p0) + (PROD_W+2)'(p1) + (PROD_W+2)'(p2)
          + ((PROD_W+2)'(1) <<< (BASIS_FRAC - 1));
      return SHIFT_W'(s >>> BASIS_FRAC);
   endfunction

   // Stage A: differences.
   logic                     a_vld_ff;
   logic signed [VEC_W-1:0]  a_d_ff [3];
   fwd_side_type             a_side_ff;

   // First normalizer output.
   logic                      n1_vld;
   logic signed [BASIS_W-1:0] n1_vec [3];
   logic [FWD_W-1:0]          n1_side_raw;
   fwd_side_type              n1_side;

   // Stages B and C: cross product of (up - eye) with N.
   logic                     b_vld_ff;
   logic signed [VEC_W-1:0]  b_prod_ff [6];
   cross_side_type           b_side_ff;
   logic                     c_vld_ff;
   logic signed [VEC_W-1:0]  c_cr_ff [3];
   cross_side_type           c_side_ff;

   // Second normalizer output.
   logic                      n2_vld;
   logic signed [BASIS_W-1:0] n2_vec [3];
   logic [CROSS_W-1:0]        n2_side_raw;
   cross_side_type            n2_side;

   // Stages D to F: V and the translations.
   logic                      d_vld_ff;
   logic signed [PROD_W-1:0]  d_vprod_ff [6];
   logic signed [PROD_W-1:0]  d_eu_ff [3];
   logic signed [PROD_W-1:0]  d_en_ff [3];
   logic signed [BASIS_W-1:0] d_u_ff [3];
   cross_side_type            d_side_ff;

   logic                      e_vld_ff;
   logic signed [BASIS_W-1:0] e_v_ff [3];
   logic signed [BASIS_W-1:0] e_u_ff [3];
   cross_side_type            e_side_ff;
   logic signed [SHIFT_W-1:0] e_shu_ff;
   logic signed [SHIFT_W-1:0] e_shn_ff;

   logic                      f_vld_ff;
   logic signed [PROD_W-1:0]  f_ev_ff [3];
   logic signed [BASIS_W-1:0] f_v_ff [3];
   logic signed [BASIS_W-1:0] f_u_ff [3];
   cross_side_type            f_side_ff;
   logic signed [SHIFT_W-1:0] f_shu_ff;
   logic signed [SHIFT_W-1:0] f_shn_ff;

   logic                      rsp_valid_ff;
   rsp_word_type              rsp_word_ff;

   logic signed [COORD_W-1:0] eye_in [3];
   logic signed [COORD_W-1:0] foc_in [3];
   logic signed [COORD_W-1:0] up_in [3];

   assign eye_in = '{req_word.eye_x, req_word.eye_y, req_word.eye_z};
   assign foc_in = '{req_word.focus_x, req_word.focus_y, req_word.focus_z};
   assign up_in  = '{req_word.up_x, req_word.up_y, req_word.up_z};

   // Stage A.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         a_d_ff[i]        <= VEC_W'(DIFF_W'(eye_in[i]) - DIFF_W'(foc_in[i]));
         a_side_ff.eye[i] <= eye_in[i];
         a_side_ff.w[i]   <= DIFF_W'(up_in[i]) - DIFF_W'(eye_in[i]);
      end
   end

   lavm_norm3 #(
      .SIDE_W (FWD_W)
   ) u_norm_n (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_vld_ff),
      .in_vec    (a_d_ff),
      .in_side   (a_side_ff),
      .out_valid (n1_vld),
      .out_vec   (n1_vec),
      .out_side  (n1_side_raw)
   );

   assign n1_side = fwd_side_type'(n1_side_raw);

   // Stage B: the six products of (up - eye) x N.
   always_ff @(posedge clock) begin
      b_prod_ff[0] <= $signed(n1_side.w[1]) * n1_vec[2];
      b_prod_ff[1] <= $signed(n1_side.w[2]) * n1_vec[1];
      b_prod_ff[2] <= $signed(n1_side.w[2]) * n1_vec[0];
      b_prod_ff[3] <= $signed(n1_side.w[0]) * n1_vec[2];
      b_prod_ff[4] <= $signed(n1_side.w[0]) * n1_vec[1];
      b_prod_ff[5] <= $signed(n1_side.w[1]) * n1_vec[0];
      b_side_ff.eye <= n1_side.eye;
      for (int i = 0; i < 3; i++) begin
         b_side_ff.n[i] <= n1_vec[i];
      end
   end

   // Stage C.
   always_ff @(posedge clock) begin
      c_cr_ff[0] <= b_prod_ff[0] - b_prod_ff[1];
      c_cr_ff[1] <= b_prod_ff[2] - b_prod_ff[3];
      c_cr_ff[2] <= b_prod_ff[4] - b_prod_ff[5];
      c_side_ff  <= b_side_ff;
   end

   lavm_norm3 #(
      .SIDE_W (CROSS_W)
   ) u_norm_u (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_vld_ff),
      .in_vec    (c_cr_ff),
      .in_side   (c_side_ff),
      .out_valid (n2_vld),
      .out_vec   (n2_vec),
      .out_side  (n2_side_raw)
   );

   assign n2_side = cross_side_type'(n2_side_raw);

   // Stage D: products for V = N x U and for eye.U, eye.N.
   always_ff @(posedge clock) begin
      d_vprod_ff[0] <= $signed(n2_side.n[1]) * n2_vec[2];
      d_vprod_ff[1] <= $signed(n2_side.n[2]) * n2_vec[1];
      d_vprod_ff[2] <= $signed(n2_side.n[2]) * n2_vec[0];
      d_vprod_ff[3] <= $signed(n2_side.n[0]) * n2_vec[2];
      d_vprod_ff[4] <= $signed(n2_side.n[0]) * n2_vec[1];
      d_vprod_ff[5] <= $signed(n2_side.n[1]) * n2_vec[0];
      for (int i = 0; i < 3; i++) begin
         d_eu_ff[i] <= $signed(n2_side.eye[i]) * n2_vec[i];
         d_en_ff[i] <= $signed(n2_side.eye[i]) * $signed(n2_side.n[i]);
         d_u_ff[i]  <= n2_vec[i];
      end
      d_side_ff <= n2_side;
   end

   // Stage E.
   always_ff @(posedge clock) begin
      e_v_ff[0] <= round_basis(VEC_W'(d_vprod_ff[0]) - VEC_W'(d_vprod_ff[1]));
      e_v_ff[1] <= round_basis(VEC_W'(d_vprod_ff[2]) - VEC_W'(d_vprod_ff[3]));
      e_v_ff[2] <= round_basis(VEC_W'(d_vprod_ff[4]) - VEC_W'(d_vprod_ff[5]));
      e_shu_ff  <= dot_round(d_eu_ff[0], d_eu_ff[1], d_eu_ff[2]);
      e_shn_ff  <= dot_round(d_en_ff[0], d_en_ff[1], d_en_ff[2]);
      e_u_ff    <= d_u_ff;
      e_side_ff <= d_side_ff;
   end

   // Stage F: eye.V products.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         f_ev_ff[i] <= $signed(e_side_ff.eye[i]) * e_v_ff[i];
      end
      f_v_ff    <= e_v_ff;
      f_u_ff    <= e_u_ff;
      f_side_ff <= e_side_ff;
      f_shu_ff  <= e_shu_ff;
      f_shn_ff  <= e_shn_ff;
   end

   // Output word register.
   always_ff @(posedge clock) begin
      rsp_word_ff.row0_u     <= f_u_ff[0];
      rsp_word_ff.row0_v     <= f_v_ff[0];
      rsp_word_ff.row0_n     <= f_side_ff.n[0];
      rsp_word_ff.row0_shift <= f_shu_ff;
      rsp_word_ff.row1_u     <= f_u_ff[1];
      rsp_word_ff.row1_v     <= f_v_ff[1];
      rsp_word_ff.row1_n     <= f_side_ff.n[1];
      rsp_word_ff.row1_shift <= dot_round(f_ev_ff[0], f_ev_ff[1], f_ev_ff[2]);
      rsp_word_ff.row2_u     <= f_u_ff[2];
      rsp_word_ff.row2_v     <= f_v_ff[2];
      rsp_word_ff.row2_n     <= f_side_ff.n[2];
      rsp_word_ff.row2_shift <= f_shn_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         f_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_vld_ff     <= start;
         b_vld_ff     <= n1_vld;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= n2_vld;
         e_vld_ff     <= d_vld_ff;
         f_vld_ff     <= e_vld_ff;
         rsp_valid_ff <= f_vld_ff;
      end
   end

   assign busy      = 1'b0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
